[rtl/core/wait_for_chain_deadlock_check_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the wait-for chain deadlock checker
// ----------------------------------------------------------------------------
`ifndef WAIT_FOR_CHAIN_DEADLOCK_CHECK_MACROS_SVH
`define WAIT_FOR_CHAIN_DEADLOCK_CHECK_MACROS_SVH

// same-cycle implication, disabled while in reset
`define WFC_AST_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wfc assertion failed");

// next-cycle implication, disabled while in reset
`define WFC_AST_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wfc assertion failed");

`endif

[rtl/core/wfc_pkg.sv]
// ----------------------------------------------------------------------------
// wfc_pkg
// Shared constants and types of the wait-for chain deadlock checker.
// ----------------------------------------------------------------------------
package wfc_pkg;

	// table sizing
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int CHAIN_DEPTH = TABLE_DEPTH + 1;
	localparam int CHN_W       = $clog2(CHAIN_DEPTH);
	localparam int LEN_W       = $clog2(CHAIN_DEPTH + 1);
	localparam int ID_W        = 16;

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

	// request kinds
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_WAIT  = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_FREE = 2'd0,
		ST_DEAD = 2'd1,
		ST_OVER = 2'd2
	} status_t;

	// table write and read commands from the sequencer
	typedef struct packed {
		logic             alloc_push;
		logic             wait_push;
		logic [ID_W-1:0]  proc_id;
		logic [ID_W-1:0]  res_id;
		logic [IDX_W-1:0] rd_idx;
	} tbl_cmd_t;

	// table fill counts and the row picked by rd_idx
	typedef struct packed {
		logic [CNT_W-1:0] alloc_used;
		logic [CNT_W-1:0] wait_used;
		logic [ID_W-1:0]  alloc_res;
		logic [ID_W-1:0]  alloc_holder;
		logic [ID_W-1:0]  wait_proc;
		logic [ID_W-1:0]  wait_res;
	} tbl_view_t;

endpackage

[rtl/core/wfc_req_if.sv]
// ----------------------------------------------------------------------------
// wfc_req_if
// Request channel: allocation or wait entry, valid/ready handshake.
// ----------------------------------------------------------------------------
interface wfc_req_if;
	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic [wfc_pkg::ID_W-1:0] proc_id;
	logic [wfc_pkg::ID_W-1:0] res_id;

	modport source (output valid, kind, proc_id, res_id, input ready);
	modport sink   (input valid, kind, proc_id, res_id, output ready);
endinterface

[rtl/core/wfc_rsp_if.sv]
// ----------------------------------------------------------------------------
// wfc_rsp_if
// Result channel: one chain position per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface wfc_rsp_if;
	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic [wfc_pkg::ID_W-1:0] chain_proc;
	logic                     last;

	modport source (output valid, status, chain_proc, last, input ready);
	modport sink   (input valid, status, chain_proc, last, output ready);
endinterface

[rtl/core/wait_for_chain_deadlock_check.sv]
// ----------------------------------------------------------------------------
// wait_for_chain_deadlock_check
// Keeps allocation and wait tables and walks the wait-for chain of each new
// wait request with one shared 16-bit comparator, reporting deadlocks.
// ----------------------------------------------------------------------------
//  port   dir   fields                         notes
//  req    sink  kind, proc_id, res_id          0 alloc entry, 1 wait entry
//  rsp    src   status, chain_proc, last       1..17 results per wait request
//
//  An alloc request is only written into its table. A wait request runs, per
//  pass, an allocation table scan, a holder check and a wait table scan, over
//  up to wait_used passes, then emits results: the single comparator sets this.
//  req.ready is high only while the sequencer is idle; rsp is a registered
//  stage, so a stalled rsp holds the walk only at its emit step.
//  Reset clears both fill counts; table contents need no clearing.
// ----------------------------------------------------------------------------
module wait_for_chain_deadlock_check (
	input  logic      clk,
	input  logic      arst_n,
	wfc_req_if.sink   req,
	wfc_rsp_if.source rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALOC,
		S_HCHK,
		S_WSCN,
		S_EMIT
	} state_t;

	state_t                     state_q;
	wfc_pkg::status_t           mode_q;
	logic [wfc_pkg::CNT_W-1:0]  scan_q;
	logic [wfc_pkg::CNT_W-1:0]  pass_q;
	logic [wfc_pkg::LEN_W-1:0]  len_q;
	logic [wfc_pkg::CHN_W-1:0]  hit_q;
	logic [wfc_pkg::CHN_W-1:0]  emit_q;
	logic [wfc_pkg::ID_W-1:0]   cur_res_q;
	logic [wfc_pkg::ID_W-1:0]   holder_q;
	logic [wfc_pkg::ID_W-1:0]   start_q;
	logic                       out_valid_q;
	wfc_pkg::status_t           out_status_q;
	logic [wfc_pkg::ID_W-1:0]   out_proc_q;
	logic                       out_last_q;
	logic [wfc_pkg::ID_W-1:0]   chain_q [wfc_pkg::CHAIN_DEPTH];

	wfc_pkg::tbl_cmd_t          cmd;
	wfc_pkg::tbl_view_t         view;
	logic                       accept;
	logic                       wait_full;
	logic                       out_free;
	logic [wfc_pkg::ID_W-1:0]   cmp_a;
	logic [wfc_pkg::ID_W-1:0]   cmp_b;
	logic                       cmp_eq;
	logic                       chain_we;
	logic [wfc_pkg::CHN_W-1:0]  chain_wa;
	logic [wfc_pkg::ID_W-1:0]   chain_wd;

	wfc_tables u_tables (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.view   (view)
	);

	// handshakes
	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign wait_full = (view.wait_used == wfc_pkg::DEPTH_CNT);
	assign out_free  = !out_valid_q || rsp.ready;

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.chain_proc = out_proc_q;
	assign rsp.last       = out_last_q;

	// table commands
	always_comb begin
		cmd.alloc_push = accept && (req.kind == wfc_pkg::KIND_ALLOC);
		cmd.wait_push  = accept && (req.kind == wfc_pkg::KIND_WAIT);
		cmd.proc_id    = req.proc_id;
		cmd.res_id     = req.res_id;
		cmd.rd_idx     = scan_q[wfc_pkg::IDX_W-1:0];
	end

	// shared comparator, operands picked by the step
	always_comb begin
		case (state_q)
			S_ALOC: begin
				cmp_a = view.alloc_res;
				cmp_b = cur_res_q;
			end
			S_HCHK: begin
				cmp_a = holder_q;
				cmp_b = start_q;
			end
			S_WSCN: begin
				cmp_a = view.wait_proc;
				cmp_b = holder_q;
			end
			default: begin
				cmp_a = '0;
				cmp_b = '0;
			end
		endcase
	end
	assign cmp_eq = (cmp_a == cmp_b);

	// chain store writes: start on accept, holders as they are found
	always_comb begin
		chain_we = 1'b0;
		chain_wa = len_q[wfc_pkg::CHN_W-1:0];
		chain_wd = view.alloc_holder;
		if (accept && (req.kind == wfc_pkg::KIND_WAIT) && !wait_full) begin
			chain_we = 1'b1;
			chain_wa = '0;
			chain_wd = req.proc_id;
		end else if ((state_q == S_ALOC) && (scan_q != view.alloc_used) && cmp_eq) begin
			chain_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (chain_we)
			chain_q[chain_wa] <= chain_wd;
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= wfc_pkg::ST_FREE;
			scan_q       <= '0;
			pass_q       <= '0;
			len_q        <= '0;
			hit_q        <= '0;
			emit_q       <= '0;
			cur_res_q    <= '0;
			holder_q     <= '0;
			start_q      <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= wfc_pkg::ST_FREE;
			out_proc_q   <= '0;
			out_last_q   <= 1'b0;
		end else begin
			// the emit step refills the register itself
			if (rsp.valid && rsp.ready && (state_q != S_EMIT))
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && (req.kind == wfc_pkg::KIND_WAIT)) begin
						emit_q <= '0;
						if (wait_full) begin
							mode_q  <= wfc_pkg::ST_OVER;
							state_q <= S_EMIT;
						end else begin
							mode_q    <= wfc_pkg::ST_FREE;
							start_q   <= req.proc_id;
							cur_res_q <= req.res_id;
							len_q     <= wfc_pkg::LEN_W'(1);
							pass_q    <= '0;
							scan_q    <= '0;
							state_q   <= S_ALOC;
						end
					end
				end
				// first holder of the awaited resource
				S_ALOC: begin
					if (scan_q == view.alloc_used) begin
						state_q <= S_EMIT;
					end else if (cmp_eq) begin
						holder_q <= view.alloc_holder;
						len_q    <= len_q + wfc_pkg::LEN_W'(1);
						state_q  <= S_HCHK;
					end else begin
						scan_q <= scan_q + wfc_pkg::CNT_W'(1);
					end
				end
				// holder back at the start closes the cycle
				S_HCHK: begin
					scan_q <= '0;
					if (cmp_eq) begin
						mode_q  <= wfc_pkg::ST_DEAD;
						hit_q   <= wfc_pkg::CHN_W'(len_q - wfc_pkg::LEN_W'(1));
						state_q <= S_EMIT;
					end else begin
						state_q <= S_WSCN;
					end
				end
				// first wait entry made by the holder
				S_WSCN: begin
					if (scan_q == view.wait_used) begin
						state_q <= S_EMIT;
					end else if (cmp_eq) begin
						cur_res_q <= view.wait_res;
						pass_q    <= pass_q + wfc_pkg::CNT_W'(1);
						scan_q    <= '0;
						if ((pass_q + wfc_pkg::CNT_W'(1)) == view.wait_used)
							state_q <= S_EMIT;
						else
							state_q <= S_ALOC;
					end else begin
						scan_q <= scan_q + wfc_pkg::CNT_W'(1);
					end
				end
				// one result per free slot in the output register
				S_EMIT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= mode_q;
						case (mode_q)
							wfc_pkg::ST_DEAD: out_proc_q <= chain_q[emit_q];
							wfc_pkg::ST_FREE: out_proc_q <= start_q;
							default:          out_proc_q <= '0;
						endcase
						if ((mode_q != wfc_pkg::ST_DEAD) || (emit_q == hit_q)) begin
							out_last_q <= 1'b1;
							state_q    <= S_IDLE;
						end else begin
							out_last_q <= 1'b0;
							emit_q     <= emit_q + wfc_pkg::CHN_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks
`include "wait_for_chain_deadlock_check_macros.svh"

	`WFC_AST_IMP(a_counts_bounded, clk, arst_n, 1'b1,
		(view.alloc_used <= wfc_pkg::DEPTH_CNT) && (view.wait_used <= wfc_pkg::DEPTH_CNT))
	`WFC_AST_IMP(a_emit_in_chain, clk, arst_n,
		(state_q == S_EMIT) && (mode_q == wfc_pkg::ST_DEAD), emit_q <= hit_q)
	`WFC_AST_IMP(a_over_shape, clk, arst_n, rsp.valid && (rsp.status == wfc_pkg::ST_OVER),
		(rsp.chain_proc == '0) && rsp.last)
	`WFC_AST_NXT(a_full_reports, clk, arst_n,
		accept && (req.kind == wfc_pkg::KIND_WAIT) && wait_full,
		(state_q == S_EMIT) && (mode_q == wfc_pkg::ST_OVER))

endmodule

[rtl/core/wfc_tables.sv]
// ----------------------------------------------------------------------------
// wfc_tables
// Allocation and wait tables, appended in arrival order, one scan port.
// ----------------------------------------------------------------------------
module wfc_tables (
	input  logic                clk,
	input  logic                arst_n,
	input  wfc_pkg::tbl_cmd_t   cmd,
	output wfc_pkg::tbl_view_t  view
);

	logic [wfc_pkg::ID_W-1:0]  alloc_res_q    [wfc_pkg::TABLE_DEPTH];
	logic [wfc_pkg::ID_W-1:0]  alloc_holder_q [wfc_pkg::TABLE_DEPTH];
	logic [wfc_pkg::ID_W-1:0]  wait_proc_q    [wfc_pkg::TABLE_DEPTH];
	logic [wfc_pkg::ID_W-1:0]  wait_res_q     [wfc_pkg::TABLE_DEPTH];
	logic [wfc_pkg::CNT_W-1:0] alloc_used_q;
	logic [wfc_pkg::CNT_W-1:0] wait_used_q;
	logic                      alloc_wr;
	logic                      wait_wr;

	// full tables drop the push
	assign alloc_wr = cmd.alloc_push && (alloc_used_q != wfc_pkg::DEPTH_CNT);
	assign wait_wr  = cmd.wait_push  && (wait_used_q  != wfc_pkg::DEPTH_CNT);

	// fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_used_q <= '0;
			wait_used_q  <= '0;
		end else begin
			if (alloc_wr)
				alloc_used_q <= alloc_used_q + wfc_pkg::CNT_W'(1);
			if (wait_wr)
				wait_used_q <= wait_used_q + wfc_pkg::CNT_W'(1);
		end
	end

	// table rows, no reset: only rows below the counts are read
	always_ff @(posedge clk) begin
		if (alloc_wr) begin
			alloc_res_q[alloc_used_q[wfc_pkg::IDX_W-1:0]]    <= cmd.res_id;
			alloc_holder_q[alloc_used_q[wfc_pkg::IDX_W-1:0]] <= cmd.proc_id;
		end
		if (wait_wr) begin
			wait_proc_q[wait_used_q[wfc_pkg::IDX_W-1:0]] <= cmd.proc_id;
			wait_res_q[wait_used_q[wfc_pkg::IDX_W-1:0]]  <= cmd.res_id;
		end
	end

	// scan port
	always_comb begin
		view.alloc_used   = alloc_used_q;
		view.wait_used    = wait_used_q;
		view.alloc_res    = alloc_res_q[cmd.rd_idx];
		view.alloc_holder = alloc_holder_q[cmd.rd_idx];
		view.wait_proc    = wait_proc_q[cmd.rd_idx];
		view.wait_res     = wait_res_q[cmd.rd_idx];
	end

endmodule
